[rtl/core/pwsc_pkg.sv]
`timescale 1ns / 1ps

package pwsc_pkg;

    // tag store geometry
    localparam int SLOT_COUNT = 64;
    localparam int SLOT_BITS  = $clog2(SLOT_COUNT);

    // request size limit, in bytes
    localparam int MAX_REQUEST_BYTES = 4096;

    // fixed field widths
    localparam int SECTOR_W  = 32;
    localparam int BOFF_W    = 16;
    localparam int COUNT_W   = 13;
    localparam int OFFSET_W  = 9;
    localparam int LENGTH_W  = 10;
    localparam int CSLOT_W   = 6;
    localparam int SECTOR_BYTES = 512;

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

    // operation codes of the input item
    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_FILL  = 2'd1;
    localparam logic [1:0] OP_FLUSH = 2'd2;

    // source codes of a result item
    localparam logic [1:0] SRC_HIT    = 2'd0;
    localparam logic [1:0] SRC_MISS   = 2'd1;
    localparam logic [1:0] SRC_DIRECT = 2'd2;

    // register indexes on the config port
    localparam logic [1:0] REG_WINDOW_START  = 2'd0;
    localparam logic [1:0] REG_WINDOW_LENGTH = 2'd1;
    localparam logic [1:0] REG_DEVICE_MEMORY = 2'd2;

    typedef enum logic [1:0] {
        KIND_READ,
        KIND_REJECT,
        KIND_FILL,
        KIND_FLUSH
    } cmd_kind_t;

    // one classified command
    typedef struct packed {
        cmd_kind_t             kind;
        logic [SECTOR_W-1:0]   sector;
        logic [OFFSET_W-1:0]   offset;
        logic [COUNT_W-1:0]    count;
    } cmd_t;

    // queue head as seen by the back end
    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } queue_head_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_READ,
        BK_EMIT
    } back_state_t;

endpackage

[rtl/core/pwsc_front.sv]
`timescale 1ns / 1ps

module pwsc_front import pwsc_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_operation,
    input  logic [SECTOR_W-1:0]   s_sector_number,
    input  logic [BOFF_W-1:0]     s_byte_offset,
    input  logic [COUNT_W-1:0]    s_byte_count,
    input  logic [SECTOR_W-1:0]   window_start,
    input  logic [SECTOR_W-1:0]   window_length,
    input  logic                  queue_full,
    output logic                  push,
    output cmd_t                  push_cmd
);

    logic [COUNT_W-1:0]   count_sat;
    logic [COUNT_W-1:0]   count_round;
    logic [3:0]           sector_span;
    logic [SECTOR_W:0]    rel;
    logic [SECTOR_W+1:0]  need;
    logic                 reject;
    logic [SECTOR_W-1:0]  abs_sector;
    logic                 accept;

    assign s_ready = !queue_full;
    assign accept  = s_valid && s_ready;

    always_comb begin
        if (32'(s_byte_count) > 32'(MAX_REQUEST_BYTES)) begin
            count_sat = COUNT_W'(MAX_REQUEST_BYTES);
        end else begin
            count_sat = s_byte_count;
        end
        // sectors touched by the count, offset in sector not counted
        // saturated count plus 511 stays below 2^13
        count_round = count_sat + COUNT_W'(SECTOR_BYTES - 1);
        sector_span = count_round[COUNT_W-1:9];
        rel         = {1'b0, s_sector_number} + (SECTOR_W+1)'(s_byte_offset[BOFF_W-1:9]);
        need        = {1'b0, rel} + (SECTOR_W+2)'(sector_span);
        reject      = need > {2'b00, window_length};
        abs_sector  = window_start + s_sector_number
                    + SECTOR_W'(s_byte_offset[BOFF_W-1:9]);
    end

    always_comb begin
        push_cmd.offset = s_byte_offset[OFFSET_W-1:0];
        push_cmd.count  = count_sat;
        push_cmd.sector = abs_sector;
        push_cmd.kind   = KIND_READ;
        push            = 1'b0;
        unique case (s_operation)
            OP_READ: begin
                push_cmd.kind = reject ? KIND_REJECT : KIND_READ;
                // a passing zero-length read leaves nothing to do
                push          = accept && (reject || (count_sat != '0));
            end
            OP_FILL: begin
                push_cmd.kind   = KIND_FILL;
                push_cmd.sector = s_sector_number;
                push            = accept;
            end
            OP_FLUSH: begin
                push_cmd.kind = KIND_FLUSH;
                push          = accept;
            end
            default: begin
                push = 1'b0;
            end
        endcase
    end

    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !queue_full)
        else $error("front pushed into a full queue");

endmodule

[rtl/core/pwsc_queue.sv]
`timescale 1ns / 1ps

module pwsc_queue import pwsc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push,
    input  cmd_t        push_cmd,
    input  logic        pop,
    output logic        full,
    output queue_head_t head
);

    cmd_t                   entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_PTR_W:0]   fill_reg, fill_next;
    logic                   do_pop;

    assign full       = fill_reg == (QUEUE_PTR_W+1)'(QUEUE_DEPTH);
    assign head.valid = fill_reg != '0;
    assign head.cmd   = entry_reg[rd_ptr_reg];
    assign do_pop     = pop && head.valid;

    always_comb begin
        wr_ptr_next = push   ? wr_ptr_reg + QUEUE_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QUEUE_PTR_W'(1) : rd_ptr_reg;
        fill_next   = fill_reg + (QUEUE_PTR_W+1)'(push) - (QUEUE_PTR_W+1)'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

[rtl/core/pwsc_back.sv]
`timescale 1ns / 1ps

module pwsc_back import pwsc_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  queue_head_t           head,
    output logic                  pop,
    input  logic                  device_is_memory,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_status,
    output logic [1:0]            m_source,
    output logic [SECTOR_W-1:0]   m_absolute_sector,
    output logic [CSLOT_W-1:0]    m_cache_slot,
    output logic [OFFSET_W-1:0]   m_offset_in_sector,
    output logic [LENGTH_W-1:0]   m_piece_length,
    output logic                  m_last_piece
);

    back_state_t state_reg, state_next;

    // piece walker
    logic [SECTOR_W-1:0]  cur_sector_reg;
    logic [OFFSET_W-1:0]  cur_offset_reg;
    logic [COUNT_W-1:0]   cur_count_reg;
    logic                 cur_reject_reg;

    // tag store
    logic [SECTOR_W-1:0]  tag_mem [SLOT_COUNT];
    logic [SECTOR_W-1:0]  tag_rd_reg;
    logic [SLOT_COUNT-1:0] valid_reg;

    // output register
    logic                 m_valid_reg;
    logic                 m_status_reg;
    logic [1:0]           m_source_reg;
    logic [SECTOR_W-1:0]  m_absolute_sector_reg;
    logic [CSLOT_W-1:0]   m_cache_slot_reg;
    logic [OFFSET_W-1:0]  m_offset_in_sector_reg;
    logic [LENGTH_W-1:0]  m_piece_length_reg;
    logic                 m_last_piece_reg;

    logic                 out_free;
    logic                 load_cur;
    logic                 tag_we;
    logic                 flush_en;
    logic                 emit;
    logic [SLOT_BITS-1:0] cur_slot;
    logic [SLOT_BITS-1:0] head_slot;
    logic [SECTOR_W-1:0]  cur_slot_wide;
    logic [LENGTH_W-1:0]  room;
    logic [LENGTH_W-1:0]  piece_len;
    logic                 piece_last;
    logic                 hit;
    logic [1:0]           piece_src;

    assign out_free      = !m_valid_reg || m_ready;
    assign cur_slot      = cur_sector_reg[SLOT_BITS-1:0];
    assign head_slot     = head.cmd.sector[SLOT_BITS-1:0];
    assign cur_slot_wide = SECTOR_W'(cur_slot);

    always_comb begin
        room = LENGTH_W'(SECTOR_BYTES) - LENGTH_W'(cur_offset_reg);
        if (cur_count_reg > COUNT_W'(room)) begin
            piece_len  = room;
            piece_last = 1'b0;
        end else begin
            piece_len  = LENGTH_W'(cur_count_reg);
            piece_last = 1'b1;
        end
        hit = valid_reg[cur_slot] && (tag_rd_reg == cur_sector_reg);
        if (device_is_memory) begin
            piece_src = SRC_DIRECT;
        end else if (hit) begin
            piece_src = SRC_HIT;
        end else begin
            piece_src = SRC_MISS;
        end
    end

    always_comb begin
        state_next = state_reg;
        pop        = 1'b0;
        load_cur   = 1'b0;
        tag_we     = 1'b0;
        flush_en   = 1'b0;
        emit       = 1'b0;
        unique case (state_reg)
            BK_IDLE: begin
                if (head.valid) begin
                    pop = 1'b1;
                    unique case (head.cmd.kind)
                        KIND_FILL: begin
                            tag_we = 1'b1;
                        end
                        KIND_FLUSH: begin
                            flush_en = 1'b1;
                        end
                        KIND_REJECT: begin
                            load_cur   = 1'b1;
                            state_next = BK_EMIT;
                        end
                        KIND_READ: begin
                            load_cur   = 1'b1;
                            state_next = BK_READ;
                        end
                        default: begin
                            pop = 1'b1;
                        end
                    endcase
                end
            end
            BK_READ: begin
                // tag read issued this cycle, compared next
                state_next = BK_EMIT;
            end
            BK_EMIT: begin
                if (out_free) begin
                    emit = 1'b1;
                    if (cur_reject_reg || piece_last) begin
                        state_next = BK_IDLE;
                    end else begin
                        state_next = BK_READ;
                    end
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BK_IDLE;
            valid_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (flush_en) begin
                valid_reg <= '0;
            end else if (tag_we) begin
                valid_reg[head_slot] <= 1'b1;
            end else if (emit && !cur_reject_reg && piece_src == SRC_MISS) begin
                valid_reg[cur_slot] <= 1'b0;
            end
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (tag_we) begin
            tag_mem[head_slot] <= head.cmd.sector;
        end
        tag_rd_reg <= tag_mem[cur_slot];
    end

    always_ff @(posedge aclk) begin
        if (load_cur) begin
            cur_sector_reg <= head.cmd.sector;
            cur_offset_reg <= head.cmd.offset;
            cur_count_reg  <= head.cmd.count;
            cur_reject_reg <= head.cmd.kind == KIND_REJECT;
        end else if (emit) begin
            cur_sector_reg <= cur_sector_reg + SECTOR_W'(1);
            cur_offset_reg <= '0;
            cur_count_reg  <= cur_count_reg - COUNT_W'(piece_len);
        end
        if (emit) begin
            if (cur_reject_reg) begin
                m_status_reg           <= 1'b1;
                m_source_reg           <= SRC_HIT;
                m_absolute_sector_reg  <= '0;
                m_cache_slot_reg       <= '0;
                m_offset_in_sector_reg <= '0;
                m_piece_length_reg     <= '0;
                m_last_piece_reg       <= 1'b1;
            end else begin
                m_status_reg           <= 1'b0;
                m_source_reg           <= piece_src;
                m_absolute_sector_reg  <= cur_sector_reg;
                m_cache_slot_reg       <= cur_slot_wide[CSLOT_W-1:0];
                m_offset_in_sector_reg <= cur_offset_reg;
                m_piece_length_reg     <= piece_len;
                m_last_piece_reg       <= piece_last;
            end
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_status           = m_status_reg;
    assign m_source           = m_source_reg;
    assign m_absolute_sector  = m_absolute_sector_reg;
    assign m_cache_slot       = m_cache_slot_reg;
    assign m_offset_in_sector = m_offset_in_sector_reg;
    assign m_piece_length     = m_piece_length_reg;
    assign m_last_piece       = m_last_piece_reg;

    a_reject_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_status_reg) |-> (m_last_piece_reg && m_piece_length_reg == '0))
        else $error("rejected result not closed or carries a length");

    a_piece_fits: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_status_reg) |->
        (m_piece_length_reg != '0 &&
         (LENGTH_W+1)'(m_piece_length_reg) + (LENGTH_W+1)'(m_offset_in_sector_reg)
             <= (LENGTH_W+1)'(SECTOR_BYTES)))
        else $error("piece runs past its sector");

    a_flush_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(flush_en) |-> (valid_reg == '0))
        else $error("flush left a valid slot");

endmodule

[rtl/core/partition_window_sector_cache_unit.sv]
`timescale 1ns / 1ps
// sequence: a read item is popped in BK_IDLE, its tag is read in BK_READ and compared in
// BK_EMIT, which loads the output register once it is free; each further piece passes
// BK_READ (registered tag read) and BK_EMIT again; a reject goes straight to BK_EMIT
// fill and flush are done in BK_IDLE; new items wait in the queue while a read is split
// reset: synchronous, active low; config registers go to 0, all slot valid bits clear at
// once, queue and output register empty; no clearing pass is needed

module partition_window_sector_cache_unit import pwsc_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    // config port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [3:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    // request channel
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_operation,
    input  logic [SECTOR_W-1:0]   s_sector_number,
    input  logic [BOFF_W-1:0]     s_byte_offset,
    input  logic [COUNT_W-1:0]    s_byte_count,
    // piece channel
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_status,
    output logic [1:0]            m_source,
    output logic [SECTOR_W-1:0]   m_absolute_sector,
    output logic [CSLOT_W-1:0]    m_cache_slot,
    output logic [OFFSET_W-1:0]   m_offset_in_sector,
    output logic [LENGTH_W-1:0]   m_piece_length,
    output logic                  m_last_piece
);

    // config registers
    logic [SECTOR_W-1:0] window_start_reg;
    logic [SECTOR_W-1:0] window_length_reg;
    logic                device_is_memory_reg;
    logic                cfg_write;
    logic [1:0]          cfg_index;

    // front to queue to back
    logic        queue_full;
    logic        push;
    cmd_t        push_cmd;
    logic        pop;
    queue_head_t head;

    assign pready    = 1'b1;
    assign cfg_index = paddr[3:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_start_reg     <= '0;
            window_length_reg    <= '0;
            device_is_memory_reg <= 1'b0;
        end else if (cfg_write) begin
            unique case (cfg_index)
                REG_WINDOW_START:  window_start_reg     <= pwdata;
                REG_WINDOW_LENGTH: window_length_reg    <= pwdata;
                REG_DEVICE_MEMORY: device_is_memory_reg <= pwdata[0];
                default: begin
                    // unmapped address, write dropped
                end
            endcase
        end
    end

    always_comb begin
        unique case (cfg_index)
            REG_WINDOW_START:  prdata = window_start_reg;
            REG_WINDOW_LENGTH: prdata = window_length_reg;
            REG_DEVICE_MEMORY: prdata = {31'd0, device_is_memory_reg};
            default:           prdata = '0;
        endcase
    end

    // classify: fold offset, window check, absolute sector
    pwsc_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_operation     (s_operation),
        .s_sector_number (s_sector_number),
        .s_byte_offset   (s_byte_offset),
        .s_byte_count    (s_byte_count),
        .window_start    (window_start_reg),
        .window_length   (window_length_reg),
        .queue_full      (queue_full),
        .push            (push),
        .push_cmd        (push_cmd)
    );

    // keeps fill, flush and read order while the back end is busy
    pwsc_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .full     (queue_full),
        .head     (head)
    );

    // split into pieces, tag lookup, output register
    pwsc_back u_back (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .head               (head),
        .pop                (pop),
        .device_is_memory   (device_is_memory_reg),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_status           (m_status),
        .m_source           (m_source),
        .m_absolute_sector  (m_absolute_sector),
        .m_cache_slot       (m_cache_slot),
        .m_offset_in_sector (m_offset_in_sector),
        .m_piece_length     (m_piece_length),
        .m_last_piece       (m_last_piece)
    );

endmodule

[tb/sector_piece_monitor.sv]
`timescale 1ns / 1ps

module sector_piece_monitor import pwsc_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic                pready,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    input  logic                s_valid,
    input  logic                s_ready,
    input  logic [1:0]          s_operation,
    input  logic [SECTOR_W-1:0] s_sector_number,
    input  logic [BOFF_W-1:0]   s_byte_offset,
    input  logic [COUNT_W-1:0]  s_byte_count,
    input  logic                m_valid,
    input  logic                m_ready,
    input  logic                m_status,
    input  logic [1:0]          m_source,
    input  logic [SECTOR_W-1:0] m_absolute_sector,
    input  logic [CSLOT_W-1:0]  m_cache_slot,
    input  logic [OFFSET_W-1:0] m_offset_in_sector,
    input  logic [LENGTH_W-1:0] m_piece_length,
    input  logic                m_last_piece,
    output int                  mismatch_count,
    output int                  pieces_outstanding
);

    typedef struct packed {
        logic                status;
        logic [1:0]          source;
        logic [SECTOR_W-1:0] abs_sector;
        logic [CSLOT_W-1:0]  slot;
        logic [OFFSET_W-1:0] offset;
        logic [LENGTH_W-1:0] length;
        logic                last;
    } piece_t;

    piece_t              pending_pieces[$];
    logic [SECTOR_W-1:0] tag_mem[SLOT_COUNT];
    bit                  tag_ok[SLOT_COUNT];
    logic [31:0]         win_start;
    logic [31:0]         win_len;
    logic                dev_mem;
    int                  errors;
    piece_t              got_piece;
    piece_t              want_piece;

    task automatic drop_all_tags();
        for (int i = 0; i < SLOT_COUNT; i++) begin
            tag_mem[i] = '1;
            tag_ok[i]  = 1'b0;
        end
    endtask

    task automatic note_mismatch(input string what, input piece_t want, input piece_t got);
        errors++;
        if (errors <= 10) begin
            $display("%0t %s: expected st=%0d src=%0d sec=%h slot=%0d ofs=%0d len=%0d last=%0d",
                     $realtime, what, want.status, want.source, want.abs_sector, want.slot,
                     want.offset, want.length, want.last);
            $display("%0t %s: actual   st=%0d src=%0d sec=%h slot=%0d ofs=%0d len=%0d last=%0d",
                     $realtime, what, got.status, got.source, got.abs_sector, got.slot,
                     got.offset, got.length, got.last);
        end
    endtask

    // works out the pieces of one accepted item and updates the tag copy
    task automatic split_read_into_pieces(input logic [1:0] op, input logic [31:0] sec,
                                          input logic [15:0] boff, input logic [12:0] cnt);
        logic [33:0]         rel;
        logic [12:0]         left;
        logic [9:0]          len;
        logic [8:0]          ofs;
        logic [31:0]         abs_s;
        logic [CSLOT_W-1:0]  slot;
        int unsigned         need;
        piece_t              p;
        case (op)
            OP_FILL: begin
                tag_mem[sec[SLOT_BITS-1:0]] = sec;
                tag_ok[sec[SLOT_BITS-1:0]]  = 1'b1;
            end
            OP_FLUSH: drop_all_tags();
            OP_READ: begin
                left = (cnt > 13'(MAX_REQUEST_BYTES)) ? 13'(MAX_REQUEST_BYTES) : cnt;
                rel  = {2'b00, sec} + 34'(boff[15:9]);
                ofs  = boff[8:0];
                need = (int'(left) + SECTOR_BYTES - 1) / SECTOR_BYTES;
                // window check ignores the offset within the sector, no wrap
                if (rel + 34'(need) > {2'b00, win_len}) begin
                    p        = '0;
                    p.status = 1'b1;
                    p.last   = 1'b1;
                    pending_pieces.push_back(p);
                end else begin
                    while (left != 0) begin
                        abs_s = win_start + rel[31:0];
                        slot  = abs_s[SLOT_BITS-1:0];
                        len   = 10'(SECTOR_BYTES) - 10'(ofs);
                        if (13'(len) > left)
                            len = left[9:0];
                        p = '0;
                        if (dev_mem) begin
                            p.source = SRC_DIRECT;
                        end else if (tag_ok[slot] && tag_mem[slot] == abs_s) begin
                            p.source = SRC_HIT;
                        end else begin
                            p.source     = SRC_MISS;
                            tag_mem[slot] = '1;
                            tag_ok[slot]  = 1'b0;
                        end
                        left         = left - 13'(len);
                        p.abs_sector = abs_s;
                        p.slot       = slot;
                        p.offset     = ofs;
                        p.length     = len;
                        p.last       = (left == 0);
                        pending_pieces.push_back(p);
                        rel = rel + 34'd1;
                        ofs = '0;
                    end
                end
            end
            default: ;
        endcase
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            pending_pieces.delete();
            drop_all_tags();
            win_start = '0;
            win_len   = '0;
            dev_mem   = 1'b0;
            errors    = 0;
        end else begin
            if (m_valid && m_ready) begin
                got_piece.status     = m_status;
                got_piece.source     = m_source;
                got_piece.abs_sector = m_absolute_sector;
                got_piece.slot       = m_cache_slot;
                got_piece.offset     = m_offset_in_sector;
                got_piece.length     = m_piece_length;
                got_piece.last       = m_last_piece;
                if (pending_pieces.size() == 0) begin
                    note_mismatch("unexpected piece", '0, got_piece);
                end else begin
                    want_piece = pending_pieces.pop_front();
                    if (got_piece.status !== want_piece.status
                        || got_piece.source !== want_piece.source
                        || got_piece.abs_sector !== want_piece.abs_sector
                        || got_piece.slot !== want_piece.slot
                        || got_piece.offset !== want_piece.offset
                        || got_piece.length !== want_piece.length
                        || got_piece.last !== want_piece.last)
                        note_mismatch("piece mismatch", want_piece, got_piece);
                end
            end
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_WINDOW_START:  win_start = pwdata;
                    REG_WINDOW_LENGTH: win_len   = pwdata;
                    REG_DEVICE_MEMORY: dev_mem   = pwdata[0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                split_read_into_pieces(s_operation, s_sector_number, s_byte_offset,
                                       s_byte_count);
        end
        mismatch_count     <= errors;
        pieces_outstanding <= pending_pieces.size();
    end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench import pwsc_pkg::*; ();

    // operation code the block must ignore
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // quiet cycles allowed before the run is declared hung
    localparam int WATCHDOG_LIMIT = 2000;
    // cycles to let a queued fill, flush or empty read finish after the last piece
    localparam int SETTLE_CYCLES  = 40;
    // items of the random part per window setting
    localparam int PHASE_ITEMS    = 50;
    localparam int PHASE_COUNT    = 6;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [3:0]            paddr = '0;
    logic [31:0]           pwdata = '0;
    logic [31:0]           prdata;
    logic                  pready;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [1:0]            s_operation = OP_READ;
    logic [SECTOR_W-1:0]   s_sector_number = '0;
    logic [BOFF_W-1:0]     s_byte_offset = '0;
    logic [COUNT_W-1:0]    s_byte_count = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic                  m_status;
    logic [1:0]            m_source;
    logic [SECTOR_W-1:0]   m_absolute_sector;
    logic [CSLOT_W-1:0]    m_cache_slot;
    logic [OFFSET_W-1:0]   m_offset_in_sector;
    logic [LENGTH_W-1:0]   m_piece_length;
    logic                  m_last_piece;

    int                    mismatch_count;
    int                    pieces_outstanding;

    // sender pacing: cycles to hold off before the next item
    int                    tx_hold = 0;
    bit                    tx_no_gap = 1'b0;
    // receiver pacing: stall left before ready comes back
    int                    ready_wait = 0;
    bit                    rx_no_stall = 1'b0;
    int                    quiet_cycles = 0;
    // items sent that the block acts on (unused op excluded)
    int                    counted_items = 0;
    logic [31:0]           cur_start = '0;

    partition_window_sector_cache_unit i_dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_operation        (s_operation),
        .s_sector_number    (s_sector_number),
        .s_byte_offset      (s_byte_offset),
        .s_byte_count       (s_byte_count),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_status           (m_status),
        .m_source           (m_source),
        .m_absolute_sector  (m_absolute_sector),
        .m_cache_slot       (m_cache_slot),
        .m_offset_in_sector (m_offset_in_sector),
        .m_piece_length     (m_piece_length),
        .m_last_piece       (m_last_piece)
    );

    // predicts every piece from the accepted items and compares what comes out
    sector_piece_monitor i_piece_monitor (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .pready             (pready),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_operation        (s_operation),
        .s_sector_number    (s_sector_number),
        .s_byte_offset      (s_byte_offset),
        .s_byte_count       (s_byte_count),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_status           (m_status),
        .m_source           (m_source),
        .m_absolute_sector  (m_absolute_sector),
        .m_cache_slot       (m_cache_slot),
        .m_offset_in_sector (m_offset_in_sector),
        .m_piece_length     (m_piece_length),
        .m_last_piece       (m_last_piece),
        .mismatch_count     (mismatch_count),
        .pieces_outstanding (pieces_outstanding)
    );

    // 12 ns clock
    always #6 aclk = ~aclk;

    // piece receiver: after each accepted piece draw a random stall unless rx_no_stall is set
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            ready_wait = 0;
        end else if (m_ready && m_valid) begin
            ready_wait = rx_no_stall ? 0 : $urandom_range(0, 16);
            if (ready_wait != 0)
                m_ready <= 1'b0;
        end else if (!m_ready) begin
            if (ready_wait <= 1)
                m_ready <= 1'b1;
            else
                ready_wait = ready_wait - 1;
        end
    end

    // watchdog: a run with nothing moving on either channel for too long is hung
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[partition_window_sector_cache_unit] ERROR");
            $finish;
        end
    end

    // present one item and hold it until taken; valid stays up when the next
    // item follows back to back, so it is never lowered and raised in one step
    task automatic send_item(input logic [1:0] op, input logic [31:0] sec,
                             input logic [15:0] boff, input logic [12:0] cnt);
        repeat (tx_hold) @(posedge aclk);
        s_valid         <= 1'b1;
        s_operation     <= op;
        s_sector_number <= sec;
        s_byte_offset   <= boff;
        s_byte_count    <= cnt;
        do @(posedge aclk); while (!s_ready);
        if (op != OP_UNUSED)
            counted_items++;
        tx_hold = tx_no_gap ? 0 : $urandom_range(0, 16);
        if (tx_hold != 0)
            s_valid <= 1'b0;
    endtask

    // sender goes quiet, every expected piece drains, then queued work settles
    task automatic pause_sender();
        if (tx_hold == 0)
            s_valid <= 1'b0;
        do @(posedge aclk); while (pieces_outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // setup cycle then access cycle; pready is always high
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // registers only change while the block is idle
    task automatic set_window(input logic [31:0] start, input logic [31:0] length,
                              input logic mem);
        pause_sender();
        write_reg(REG_WINDOW_START, start);
        write_reg(REG_WINDOW_LENGTH, length);
        write_reg(REG_DEVICE_MEMORY, {31'd0, mem});
        cur_start = start;
    endtask

    // mostly reads near the window start and fills of the same sectors so that
    // hits, misses and evictions all happen; the rest is noise
    task automatic send_random_item();
        int          pick;
        logic [15:0] boff;
        logic [12:0] cnt;
        pick = $urandom_range(0, 99);
        cnt  = ($urandom_range(0, 9) == 0) ? 13'($urandom_range(0, 8191))
                                            : 13'($urandom_range(0, MAX_REQUEST_BYTES));
        boff = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1023));
        if (pick < 50)
            send_item(OP_READ, $urandom_range(0, 40), boff, cnt);
        else if (pick < 75)
            send_item(OP_FILL, cur_start + $urandom_range(0, 48), 16'($urandom),
                      13'($urandom));
        else if (pick < 80)
            send_item(OP_FLUSH, $urandom, 16'($urandom), 13'($urandom));
        else if (pick < 83)
            send_item(OP_UNUSED, $urandom, 16'($urandom), 13'($urandom));
        else
            send_item(OP_READ, $urandom, 16'($urandom), 13'($urandom));
    endtask

    initial begin
        logic [31:0] start;
        logic [31:0] length;
        logic        mem;
        int          target;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: window that wraps past the top of the sector space
        set_window(32'hFFFF_FFF8, 32'hFFFF_FFFF, 1'b0);
        send_item(OP_READ, 32'd0, 16'd0, 13'd512);              // cold miss
        send_item(OP_FILL, 32'hFFFF_FFF8, 16'd0, 13'd0);
        send_item(OP_FILL, 32'hFFFF_FFFF, 16'd0, 13'd0);        // all-ones tag
        send_item(OP_READ, 32'd0, 16'd0, 13'd4096);             // hit, misses, hit
        send_item(OP_READ, 32'd0, 16'hFFFF, 13'd4096);          // nine pieces, wraps
        send_item(OP_READ, 32'd5, 16'd0, 13'd0);                // zero bytes, no piece
        send_item(OP_READ, 32'd0, 16'h0200, 13'h1FFF);          // oversized count
        send_item(OP_READ, 32'd3, 16'd100, 13'd4097);           // just over the limit
        send_item(OP_READ, 32'hFFFF_FFFF, 16'd0, 13'd0);        // passes the check
        send_item(OP_READ, 32'hFFFF_FFFF, 16'd0, 13'd1);        // sum overflows 32 bits
        send_item(OP_READ, 32'hFFFF_FFFF, 16'hFFFF, 13'h1FFF);  // everything at max
        send_item(OP_READ, 32'hFFFF_FF00, 16'd0, 13'd1);
        send_item(OP_FILL, 32'hFFFF_FFF8, 16'd0, 13'd0);
        send_item(OP_FLUSH, 32'd0, 16'd0, 13'd0);
        send_item(OP_READ, 32'd0, 16'd0, 13'd512);              // miss after flush
        send_item(OP_UNUSED, 32'hFFFF_FFFF, 16'hFFFF, 13'h1FFF);
        send_item(OP_READ, 32'd0, 16'd511, 13'd2);              // straddles a boundary

        // empty window: only zero-byte reads at sector 0 get through
        set_window(32'd0, 32'd0, 1'b0);
        send_item(OP_READ, 32'd0, 16'd0, 13'd0);
        send_item(OP_READ, 32'd0, 16'd0, 13'd1);

        // memory device: pieces bypass the tags but a fill still installs
        set_window(32'h1234_5678, 32'd100, 1'b1);
        send_item(OP_READ, 32'd10, 16'd300, 13'd1000);
        send_item(OP_FILL, 32'h1234_5682, 16'd0, 13'd0);
        send_item(OP_READ, 32'd99, 16'd0, 13'd512);             // last sector of window
        send_item(OP_READ, 32'd99, 16'd0, 13'd513);             // one sector too far
        set_window(32'h1234_5678, 32'd100, 1'b0);
        send_item(OP_READ, 32'd10, 16'd0, 13'd512);             // hits the earlier fill

        // random part, one window setting per phase, extremes included
        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            case (phase)
                0: begin start = 32'd0;        length = 32'hFFFF_FFFF;            mem = 1'b0; end
                1: begin start = 32'hFFFF_FFFF; length = $urandom_range(100, 300); mem = 1'b0; end
                2: begin start = $urandom;      length = $urandom_range(20, 80);   mem = 1'b1; end
                3: begin start = $urandom;      length = 32'd0;                    mem = 1'b0; end
                4: begin start = $urandom;      length = $urandom_range(150, 400); mem = 1'b0; end
                default: begin start = $urandom; length = 32'hFFFF_FFFF;           mem = 1'b1; end
            endcase
            set_window(start, length, mem);
            // some phases run flat out on one or both sides
            tx_no_gap   = ($urandom_range(0, 3) == 0);
            rx_no_stall = ($urandom_range(0, 3) == 0);
            target = counted_items + PHASE_ITEMS;
            while (counted_items < target) begin
                send_random_item();
                // occasionally let everything drain mid-phase
                if ($urandom_range(0, 49) == 0)
                    pause_sender();
            end
        end

        pause_sender();
        if (mismatch_count == 0 && pieces_outstanding == 0)
            $display("[partition_window_sector_cache_unit] OK");
        else
            $display("[partition_window_sector_cache_unit] ERROR");
        $finish;
    end

endmodule
